[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SHA-256 checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define S256_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define S256_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/s256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, initial hash value, round constants and sigma functions.
// ----------------------------------------------------------------------------
package s256_pkg;

    // Initial hash value, H0 in the top word
    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Control from the sequencer to the message schedule
    typedef struct packed {
        logic       push;      // append one message byte
        logic       word_end;  // byte completes a 32-bit word
        logic       step;      // advance the schedule by one round
        logic [7:0] byte_val;
    } t_sched_ctrl;

    // Control from the sequencer to the round core
    typedef struct packed {
        logic       load;      // copy hash into the working variables
        logic       step;      // run one round
        logic       fold;      // add working variables into the hash
        logic       init;      // return hash to the initial value
        logic [5:0] rnd;       // round index
    } t_core_ctrl;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // Round constant table
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        case (idx)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

[rtl/s256_sched.sv]
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Packs bytes into words and holds the 16-word window; expands one word
// per round while the window slides.
// ----------------------------------------------------------------------------
module s256_sched
    import s256_pkg::*;
(
    input  logic        i_clk,
    input  t_sched_ctrl i_ctrl,
    output logic [31:0] o_w
);

    localparam int unsigned WIN = 16;

    logic [23:0] r_word;
    logic [31:0] r_win [WIN];
    logic [31:0] n_word_full;
    logic [31:0] n_expand;

    // Complete word and next expanded word
    assign n_word_full = {r_word, i_ctrl.byte_val};
    assign n_expand    = small_sigma1(r_win[14]) + r_win[9]
                       + small_sigma0(r_win[1]) + r_win[0];

    // Collect bytes of the current word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_word <= n_word_full[23:0];
        end
    end

    // Slide the window on a finished word or a round
    always_ff @(posedge i_clk) begin
        if ((i_ctrl.push && i_ctrl.word_end) || i_ctrl.step) begin
            for (int i = 0; i < WIN - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WIN - 1] <= i_ctrl.step ? n_expand : n_word_full;
        end
    end

    // Oldest word is the one for the current round
    assign o_w = r_win[0];

endmodule

[rtl/s256_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 round core
// Holds the hash words and the working variables; runs one compression
// round per cycle while step is set and folds the result into the hash.
// ----------------------------------------------------------------------------
module s256_core
    import s256_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_core_ctrl   i_ctrl,
    input  logic [31:0]  i_w,
    output logic [255:0] o_hash
);

    logic [255:0] r_hash;
    logic [255:0] r_v;
    logic [255:0] n_hash;
    logic [31:0]  a, b, c, d, e, f, g, h;
    logic [31:0]  t1, t2;

    assign {a, b, c, d, e, f, g, h} = r_v;

    // One round
    assign t1 = h + big_sigma1(e) + ((e & f) ^ (~e & g)) + round_k(i_ctrl.rnd) + i_w;
    assign t2 = big_sigma0(a) + ((a & b) ^ (a & c) ^ (b & c));

    // Word-wise add of working variables into hash
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_hash[32 * i +: 32] = r_hash[32 * i +: 32] + r_v[32 * i +: 32];
        end
    end

    // Hash words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= H_INIT;
        end else if (i_ctrl.init) begin
            r_hash <= H_INIT;
        end else if (i_ctrl.fold) begin
            r_hash <= n_hash;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_v <= r_hash;
        end else if (i_ctrl.step) begin
            r_v <= {t1 + t2, a, b, c, d + t1, e, f, g};
        end
    end

    assign o_hash = r_hash;

endmodule

[rtl/sha256_stream_hasher.sv]
// Flow: a word that fills a 64-byte block is followed by 64 rounds on the shared round core
// plus one hash fold. A last word adds padding at one byte per cycle between compressions
// (9 to 72 bytes), one or two compressions and an output that waits for a free output register.
// Input bytes are not taken while a block is compressed, since there is a single round unit.
// Reset: synchronous, active low; hash returns to the initial value, counts clear.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with padding sequencer and registered digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
    import s256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_part0,
    output logic [63:0] o_digest_part1,
    output logic [63:0] o_digest_part2,
    output logic [63:0] o_digest_part3
);

    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [4:0] {
        S_IN   = 5'b00001,
        S_PAD  = 5'b00010,
        S_COMP = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_pos, n_pos;
    logic [63:0]  r_bit_cnt, n_bit_cnt;
    logic [5:0]   r_rnd, n_rnd;
    logic         r_pad, n_pad;
    logic         r_first, n_first;
    logic         r_lenph, n_lenph;
    logic         r_final, n_final;
    logic         r_ovalid, n_ovalid;
    logic [255:0] r_dig;

    t_sched_ctrl  sched_ctrl;
    t_core_ctrl   core_ctrl;
    logic [31:0]  w_cur;
    logic [255:0] hash;
    logic         push;
    logic         wrap;
    logic         len_byte;
    logic         out_free;
    logic         emit;
    logic [7:0]   pad_byte;

    // Byte source: input word or padding generator
    assign len_byte = !r_first && (r_lenph || (r_pos == LEN_POS));
    assign pad_byte = r_first ? PAD_MARK : (len_byte ? r_bit_cnt[63:56] : 8'h00);
    assign push     = ((r_state == S_IN) && i_valid && i_has_byte) || (r_state == S_PAD);
    assign wrap     = push && (&r_pos);
    assign out_free = !r_ovalid || i_ready;
    assign emit     = (r_state == S_OUT) && out_free;

    assign sched_ctrl.push     = push;
    assign sched_ctrl.word_end = &r_pos[1:0];
    assign sched_ctrl.step     = (r_state == S_COMP);
    assign sched_ctrl.byte_val = (r_state == S_IN) ? i_data_byte : pad_byte;

    assign core_ctrl.load = wrap;
    assign core_ctrl.step = (r_state == S_COMP);
    assign core_ctrl.fold = (r_state == S_FIN);
    assign core_ctrl.init = emit;
    assign core_ctrl.rnd  = r_rnd;

    s256_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w    (w_cur)
    );

    s256_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (core_ctrl),
        .i_w     (w_cur),
        .o_hash  (hash)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_bit_cnt = r_bit_cnt;
        n_rnd     = r_rnd;
        n_pad     = r_pad;
        n_first   = r_first;
        n_lenph   = r_lenph;
        n_final   = r_final;
        n_ovalid  = r_ovalid;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (push) begin
            n_pos = r_pos + 6'd1;
        end

        case (r_state)
            S_IN: begin
                if (i_valid) begin
                    if (i_has_byte) begin
                        n_bit_cnt = r_bit_cnt + 64'd8;
                    end
                    if (i_last) begin
                        n_pad   = 1'b1;
                        n_first = 1'b1;
                    end
                    if (wrap) begin
                        n_state = S_COMP;
                        n_rnd   = '0;
                    end else if (i_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                n_first = 1'b0;
                if (len_byte) begin
                    n_lenph   = 1'b1;
                    n_bit_cnt = {r_bit_cnt[55:0], 8'h00};
                end
                if (wrap) begin
                    n_state = S_COMP;
                    n_rnd   = '0;
                    n_final = len_byte;
                end
            end
            S_COMP: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == LAST_RND) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_final) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IN;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_pad    = 1'b0;
                    n_lenph  = 1'b0;
                    n_final  = 1'b0;
                    n_state  = S_IN;
                end
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IN;
            r_pos     <= '0;
            r_bit_cnt <= '0;
            r_rnd     <= '0;
            r_pad     <= 1'b0;
            r_first   <= 1'b0;
            r_lenph   <= 1'b0;
            r_final   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_bit_cnt <= n_bit_cnt;
            r_rnd     <= n_rnd;
            r_pad     <= n_pad;
            r_first   <= n_first;
            r_lenph   <= n_lenph;
            r_final   <= n_final;
            r_ovalid  <= n_ovalid;
        end
    end

    // Hold digest for the output word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_dig <= hash;
        end
    end

    assign o_ready        = (r_state == S_IN);
    assign o_valid        = r_ovalid;
    assign o_digest_part0 = r_dig[255:192];
    assign o_digest_part1 = r_dig[191:128];
    assign o_digest_part2 = r_dig[127:64];
    assign o_digest_part3 = r_dig[63:0];

endmodule

[rtl/s256_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module s256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_has_byte,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_digest_part0,
    input logic [63:0] o_digest_part1,
    input logic [63:0] o_digest_part2,
    input logic [63:0] o_digest_part3
);

    logic [9:0]   in_word;
    logic [255:0] out_word;

    // Gather each side's payload into one vector
    assign in_word  = {i_data_byte, i_has_byte, i_last};
    assign out_word = {o_digest_part0, o_digest_part1, o_digest_part2, o_digest_part3};

    // Hold a waiting input word
    `S256_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(in_word), "input word dropped or changed while waiting")

    // Hold a stalled digest word
    `S256_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(out_word), "digest dropped or changed while stalled")

    // Drop ready after the end of a message
    `S256_ASSERT_NXT(a_last_busy, i_clk, i_rst_n, i_valid && o_ready && i_last, !o_ready, "input ready right after a last word")

    // Raise a digest only after the block was busy
    `S256_ASSERT_IMP(a_out_busy, i_clk, i_rst_n, $rose(o_valid), !$past(o_ready), "digest appeared while input was ready")

endmodule

bind sha256_stream_hasher s256_checker u_s256_checker (.*);
